@@ sv/chp_pkg.sv @@
// Package for the color histogram block: sizes, item and register codes,
// controller command and status structs, and the bin mapping functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chp_pkg;

    localparam int CHANNEL_BINS = 256;
    localparam int COUNT_WIDTH  = 25;

    localparam int BIN_W   = $clog2(CHANNEL_BINS);
    localparam int CBIN_W  = $clog2(CHANNEL_BINS + 1);
    localparam int IDX_W   = 9;
    localparam int BYTE_W  = 8;
    localparam int MODE_W  = 2;
    localparam int DIM_W   = 13;
    localparam int LIMIT_W = 2 * DIM_W;
    localparam int CMP_W   = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Item modes; the fourth code carries no meaning and is dropped.
    localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHMODE = 2'd2;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic capture;
        logic issue;
        logic write;
        logic load_out;
        logic clear_start;
        logic clear_step;
    } t_cmd;

    typedef struct packed {
        logic is_pixel;
        logic is_read;
        logic is_clear;
        logic pix_ok;
        logic clear_done;
        logic out_free;
    } t_status;

    function automatic logic [BIN_W-1:0] f_chan_bin(input logic [BYTE_W-1:0] v);
        logic [BYTE_W+BIN_W:0] p;
        p = (BYTE_W + BIN_W + 1)'(v) * (BYTE_W + BIN_W + 1)'(CHANNEL_BINS);
        return BIN_W'(p >> BYTE_W);
    endfunction

    // Combined bin is the packed BGR word scaled to the bin count, rounded up.
    function automatic logic [CBIN_W-1:0] f_comb_bin(input logic [BYTE_W-1:0] b,
                                                      input logic [BYTE_W-1:0] g,
                                                      input logic [BYTE_W-1:0] r);
        logic [3*BYTE_W+BIN_W+1:0] p;
        logic [BIN_W+1:0]          q;
        p = (3*BYTE_W + BIN_W + 2)'({b, g, r}) * (3*BYTE_W + BIN_W + 2)'(CHANNEL_BINS)
            + (3*BYTE_W + BIN_W + 2)'({(3*BYTE_W){1'b1}});
        q = (BIN_W + 2)'(p >> (3*BYTE_W));
        if (q > (BIN_W + 2)'(CHANNEL_BINS)) begin
            q = (BIN_W + 2)'(CHANNEL_BINS);
        end
        return CBIN_W'(q);
    endfunction

endpackage

`default_nettype wire

@@ sv/chp_pix_if.sv @@
// Input channel of the color histogram block: valid/ready plus item payload.
// Depends on chp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface chp_pix_if import chp_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [BYTE_W-1:0]   blue;
    logic [BYTE_W-1:0]   green;
    logic [BYTE_W-1:0]   red;
    logic [IDX_W-1:0]    bin_index;

    modport source (output valid, mode, blue, green, red, bin_index, input ready);
    modport sink   (input valid, mode, blue, green, red, bin_index, output ready);
endinterface

`default_nettype wire

@@ sv/chp_res_if.sv @@
// Result channel of the color histogram block: valid/ready plus read result.
// Depends on chp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface chp_res_if import chp_pkg::*; ;
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] blue_count;
    logic [COUNT_WIDTH-1:0] green_count;
    logic [COUNT_WIDTH-1:0] red_count;
    logic [COUNT_WIDTH-1:0] combined_count;
    logic [COUNT_WIDTH-1:0] blue_peak;
    logic [COUNT_WIDTH-1:0] green_peak;
    logic [COUNT_WIDTH-1:0] red_peak;
    logic [COUNT_WIDTH-1:0] combined_peak;
    logic [COUNT_WIDTH-1:0] pixels_seen;

    modport source (output valid, blue_count, green_count, red_count, combined_count,
                    blue_peak, green_peak, red_peak, combined_peak, pixels_seen,
                    input ready);
    modport sink   (input valid, blue_count, green_count, red_count, combined_count,
                    blue_peak, green_peak, red_peak, combined_peak, pixels_seen,
                    output ready);
endinterface

`default_nettype wire

@@ sv/color_histogram_with_peaks.sv @@
// Top level of the color histogram block: controller plus datapath.
// Depends on chp_pkg, chp_pix_if, chp_res_if, chp_ctrl and chp_dp.
//
// Usage: items come in on i_pix (valid/ready); a transfer is one item. A
// pixel item adds one to the blue, green, red and combined histograms (blue
// only in gray mode) until width times height pixels have been counted. A
// read item returns one result on o_res with the four counts at bin_index,
// the four peaks and the pixel count. A clear item zeroes the memories,
// peaks and pixel count. Configuration is written through i_cfg_we /
// i_cfg_index / i_cfg_data. A pixel passes through capture, memory read
// and update; a read through capture, memory read and loading of the result
// register; a clear through capture, memory read and the clearing pass. A new
// item is taken only once the last is through; the single-port read-modify-
// write of the bin memories sets these steps. After reset a clearing pass
// zeroes the memories while i_pix.ready stays low. A read result waits in the
// output register while o_res.ready is low; the next item is still taken,
// and a following read waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module color_histogram_with_peaks import chp_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    chp_pix_if.sink              i_pix,
    chp_res_if.source            o_res,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    chp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    chp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_pix.mode),
        .i_blue      (i_pix.blue),
        .i_green     (i_pix.green),
        .i_red       (i_pix.red),
        .i_bin_index (i_pix.bin_index),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_res       (o_res)
    );

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear_step |-> !i_pix.ready)
        else $error("item transfer offered during clearing pass");

    a_count_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.blue_count <= o_res.blue_peak))
        else $error("blue count above blue peak");

    a_peak_le_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.combined_peak <= o_res.pixels_seen))
        else $error("combined peak above pixel count");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.issue, cmd.write, cmd.load_out, cmd.clear_step}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

@@ sv/chp_ctrl.sv @@
// Controller of the color histogram block: sequences capture, memory read,
// update, read response and clearing pass. Depends on chp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chp_ctrl import chp_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ISSUE = 5'b00100,
        S_WRITE = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (i_status.is_pixel) begin
                    n_state = i_status.pix_ok ? S_WRITE : S_IDLE;
                end else if (i_status.is_read) begin
                    n_state = S_RESP;
                end else if (i_status.is_clear) begin
                    o_cmd.clear_start = 1'b1;
                    n_state           = S_CLEAR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_IDLE;
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/chp_dp.sv @@
// Datapath of the color histogram block: configuration registers, the four
// bin memories, peaks, pixel counter and result register. Depends on chp_pkg
// and chp_res_if.
`timescale 1ns / 1ps
`default_nettype none

module chp_dp import chp_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire [MODE_W-1:0]       i_mode,
    input  wire [BYTE_W-1:0]       i_blue,
    input  wire [BYTE_W-1:0]       i_green,
    input  wire [BYTE_W-1:0]       i_red,
    input  wire [IDX_W-1:0]        i_bin_index,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    chp_res_if.source              o_res
);

    logic [DIM_W-1:0]   r_width, r_height;
    logic               r_chmode;
    logic [LIMIT_W-1:0] r_limit;

    logic [MODE_W-1:0]  r_mode;
    logic [BYTE_W-1:0]  r_blue, r_green, r_red;
    logic [IDX_W-1:0]   r_idx;

    logic [COUNT_WIDTH-1:0] mem_b [CHANNEL_BINS];
    logic [COUNT_WIDTH-1:0] mem_g [CHANNEL_BINS];
    logic [COUNT_WIDTH-1:0] mem_r [CHANNEL_BINS];
    logic [COUNT_WIDTH-1:0] mem_c [CHANNEL_BINS+1];
    logic [COUNT_WIDTH-1:0] r_rd_b, r_rd_g, r_rd_r, r_rd_c;

    logic [COUNT_WIDTH-1:0] r_peak_b, r_peak_g, r_peak_r, r_peak_c;
    logic [COUNT_WIDTH-1:0] r_pixels;
    logic [CBIN_W-1:0]      r_clr_addr;
    logic                   r_out_valid;

    logic [BIN_W-1:0]       bin_b, bin_g, bin_r, ch_addr, clr_ch_addr;
    logic [CBIN_W-1:0]      bin_c, cb_addr;
    logic                   chan_ok, comb_ok, clr_ch_ok;
    logic                   we_b, we_gr, we_c;
    logic [COUNT_WIDTH-1:0] inc_b, inc_g, inc_r, inc_c;
    logic [COUNT_WIDTH-1:0] wd_b, wd_g, wd_r, wd_c;
    logic [BIN_W-1:0]       wa_b, wa_g, wa_r;
    logic [CBIN_W-1:0]      wa_c;

    // Configuration; the frame limit is registered from the product of the size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_chmode <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_index == REG_HEIGHT) begin
                r_height <= i_cfg_data;
            end
            if (i_cfg_index == REG_CHMODE) begin
                r_chmode <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= LIMIT_W'(r_width) * LIMIT_W'(r_height);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_blue  <= i_blue;
            r_green <= i_green;
            r_red   <= i_red;
            r_idx   <= i_bin_index;
        end
    end

    assign bin_b   = f_chan_bin(r_blue);
    assign bin_g   = f_chan_bin(r_green);
    assign bin_r   = f_chan_bin(r_red);
    assign bin_c   = f_comb_bin(r_blue, r_green, r_red);
    assign chan_ok = r_idx < IDX_W'(CHANNEL_BINS);
    assign comb_ok = r_idx <= IDX_W'(CHANNEL_BINS);
    assign ch_addr = BIN_W'(r_idx);
    assign cb_addr = CBIN_W'(r_idx);

    assign clr_ch_addr = BIN_W'(r_clr_addr);
    assign clr_ch_ok   = r_clr_addr < CBIN_W'(CHANNEL_BINS);

    assign inc_b = r_rd_b + 1'b1;
    assign inc_g = r_rd_g + 1'b1;
    assign inc_r = r_rd_r + 1'b1;
    assign inc_c = r_rd_c + 1'b1;

    // Write port: pixel update or zero during the clearing pass.
    assign we_b  = i_cmd.write || (i_cmd.clear_step && clr_ch_ok);
    assign we_gr = (i_cmd.write && r_chmode) || (i_cmd.clear_step && clr_ch_ok);
    assign we_c  = (i_cmd.write && r_chmode) || i_cmd.clear_step;
    assign wa_b  = i_cmd.clear_step ? clr_ch_addr : bin_b;
    assign wa_g  = i_cmd.clear_step ? clr_ch_addr : bin_g;
    assign wa_r  = i_cmd.clear_step ? clr_ch_addr : bin_r;
    assign wa_c  = i_cmd.clear_step ? r_clr_addr : bin_c;
    assign wd_b  = i_cmd.clear_step ? '0 : inc_b;
    assign wd_g  = i_cmd.clear_step ? '0 : inc_g;
    assign wd_r  = i_cmd.clear_step ? '0 : inc_r;
    assign wd_c  = i_cmd.clear_step ? '0 : inc_c;

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            mem_b[wa_b] <= wd_b;
        end
        if (we_gr) begin
            mem_g[wa_g] <= wd_g;
            mem_r[wa_r] <= wd_r;
        end
        if (we_c) begin
            mem_c[wa_c] <= wd_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            if (r_mode == MODE_PIXEL) begin
                r_rd_b <= mem_b[bin_b];
                r_rd_g <= mem_g[bin_g];
                r_rd_r <= mem_r[bin_r];
                r_rd_c <= mem_c[bin_c];
            end else begin
                r_rd_b <= mem_b[ch_addr];
                r_rd_g <= mem_g[ch_addr];
                r_rd_r <= mem_r[ch_addr];
                r_rd_c <= mem_c[cb_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_start) begin
            r_peak_b   <= '0;
            r_peak_g   <= '0;
            r_peak_r   <= '0;
            r_peak_c   <= '0;
            r_pixels   <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear_step && clr_ch_ok) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.write) begin
                r_pixels <= r_pixels + 1'b1;
                if (inc_b > r_peak_b) begin
                    r_peak_b <= inc_b;
                end
                if (r_chmode) begin
                    if (inc_g > r_peak_g) begin
                        r_peak_g <= inc_g;
                    end
                    if (inc_r > r_peak_r) begin
                        r_peak_r <= inc_r;
                    end
                    if (inc_c > r_peak_c) begin
                        r_peak_c <= inc_c;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_res.blue_count     <= chan_ok ? r_rd_b : '0;
            o_res.green_count    <= chan_ok ? r_rd_g : '0;
            o_res.red_count      <= chan_ok ? r_rd_r : '0;
            o_res.combined_count <= comb_ok ? r_rd_c : '0;
            o_res.blue_peak      <= r_peak_b;
            o_res.green_peak     <= r_peak_g;
            o_res.red_peak       <= r_peak_r;
            o_res.combined_peak  <= r_peak_c;
            o_res.pixels_seen    <= r_pixels;
        end
    end

    assign o_res.valid = r_out_valid;

    assign o_status.is_pixel   = r_mode == MODE_PIXEL;
    assign o_status.is_read    = r_mode == MODE_READ;
    assign o_status.is_clear   = r_mode == MODE_CLEAR;
    assign o_status.pix_ok     = (CMP_W'(r_pixels) < CMP_W'(r_limit))
                                 && (r_pixels < COUNT_MAX);
    assign o_status.clear_done = r_clr_addr == CBIN_W'(CHANNEL_BINS);
    assign o_status.out_free   = !r_out_valid || o_res.ready;

endmodule

`default_nettype wire
